[rtl/nearest_free_grid_cell_search_assert.svh]
// Assertion macros for the nearest free cell search block.
// Each expects clk and arst_n in scope.
`ifndef NEAREST_FREE_GRID_CELL_SEARCH_ASSERT_SVH
`define NEAREST_FREE_GRID_CELL_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define NFGCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nfgcs: same-cycle check failed");

// Next-cycle implication.
`define NFGCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nfgcs: next-cycle check failed");

`endif

[rtl/nfgcs_pkg.sv]
`default_nettype none

package nfgcs_pkg;

	// Default sizes of the grid store and scan window
	localparam int GRID_WIDTH_MAX_DEF  = 256;
	localparam int GRID_HEIGHT_MAX_DEF = 256;
	localparam int RADIUS_MAX_DEF      = 31;

	// Field widths
	localparam int COORD_IN_W = 11;
	localparam int DIM_CFG_W  = 9;
	localparam int RAD_W      = 5;
	localparam int SQ_W       = 11;
	localparam int OUT_XY_W   = 8;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Internal widths: candidate coordinates, effective dimensions, scan offsets
	localparam int COORD_W = 13;
	localparam int DIM_W   = 13;
	localparam int OFS_W   = 7;

	// Register reset values
	localparam logic [DIM_CFG_W-1:0] GRID_WIDTH_RST  = 9'd256;
	localparam logic [DIM_CFG_W-1:0] GRID_HEIGHT_RST = 9'd256;
	localparam logic [RAD_W-1:0]     RADIUS_RST      = 5'd0;
	localparam logic [SQ_W-1:0]      MAX_SQ_RST      = 11'd0;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SQ      = 2'd3;

	// Opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_WRITTEN  = 3'd0,
		ST_FREE     = 3'd1,
		ST_ADJUSTED = 3'd2,
		ST_OOB      = 3'd3,
		ST_NONE     = 3'd4
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;
		logic    clr_step;
		logic    wr_cell;
		logic    peek;
		logic    scan_init;
		logic    scan_step;
		logic    load_out;
		status_t res_status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_done;
		logic is_query;
		logic req_in_grid;
		logic peek_free;
		logic scan_last;
		logic found;
	} sts_t;

endpackage

`default_nettype wire

[rtl/nearest_free_grid_cell_search.sv]
`default_nettype none

// Channel   Handshake             Beat contents
// input     in_valid / in_ready   opcode, cell_x, cell_y, occupied
// result    out_valid / out_ready status, found_x, found_y, squared_distance
// config    cfg_we                cfg_index, cfg_data (write only, no wait)
//
// After reset the occupancy store is swept to free, one cell a cycle, over
// all GRID_WIDTH_MAX*GRID_HEIGHT_MAX cells (65536 by default) with in_ready low.
// A write or a query outside the grid ends at the check, a free requested cell
// at the peek; an occupied one scans the (2r+1)^2 window, r the clipped search
// radius, one cell a cycle through the single read port of the store.
// One item is in flight at a time; the next beat is taken while a finished
// result still waits for out_ready.
module nearest_free_grid_cell_search #(
	parameter int GRID_WIDTH_MAX  = nfgcs_pkg::GRID_WIDTH_MAX_DEF,
	parameter int GRID_HEIGHT_MAX = nfgcs_pkg::GRID_HEIGHT_MAX_DEF,
	parameter int RADIUS_MAX      = nfgcs_pkg::RADIUS_MAX_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [nfgcs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nfgcs_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   opcode,
	input  logic signed [nfgcs_pkg::COORD_IN_W-1:0] cell_x,
	input  logic signed [nfgcs_pkg::COORD_IN_W-1:0] cell_y,
	input  logic                                   occupied,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [nfgcs_pkg::STATUS_W-1:0]         status,
	output logic [nfgcs_pkg::OUT_XY_W-1:0]         found_x,
	output logic [nfgcs_pkg::OUT_XY_W-1:0]         found_y,
	output logic [nfgcs_pkg::SQ_W-1:0]             squared_distance
);
	import nfgcs_pkg::*;

	// Commands down, status up; nothing else crosses between the two halves
	cmd_t cmd;
	sts_t sts;

	// Sequencer: clearing sweep, request check, peek, scan, result hand-off
	nfgcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Store, registers, offset counters, best-cell tracking and result register
	nfgcs_dpath #(
		.GRID_WIDTH_MAX  (GRID_WIDTH_MAX),
		.GRID_HEIGHT_MAX (GRID_HEIGHT_MAX),
		.RADIUS_MAX      (RADIUS_MAX)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.opcode           (opcode),
		.cell_x           (cell_x),
		.cell_y           (cell_y),
		.occupied         (occupied),
		.cmd              (cmd),
		.sts              (sts),
		.status           (status),
		.found_x          (found_x),
		.found_y          (found_y),
		.squared_distance (squared_distance)
	);

endmodule

`default_nettype wire

[rtl/nfgcs_ctrl.sv]
`default_nettype none

module nfgcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output nfgcs_pkg::cmd_t   cmd,
	input  nfgcs_pkg::sts_t   sts
);
	import nfgcs_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_PEEK,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t  state_q;
	status_t res_q;
	logic    out_valid_q;
	logic    out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.res_status = res_q;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: cmd.capture = in_valid;
			S_CHECK: begin
				cmd.wr_cell = !sts.is_query && sts.req_in_grid;
				cmd.peek    = sts.is_query && sts.req_in_grid;
			end
			S_PEEK: cmd.scan_init = !sts.peek_free;
			S_SCAN: cmd.scan_step = 1'b1;
			S_FINISH: begin
				cmd.load_out   = out_free;
				// a scan that found nothing reports none found
				if (res_q == ST_ADJUSTED && !sts.found) begin
					cmd.res_status = ST_NONE;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_q       <= ST_WRITTEN;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!sts.is_query) begin
						res_q   <= ST_WRITTEN;
						state_q <= S_FINISH;
					end else if (!sts.req_in_grid) begin
						res_q   <= ST_OOB;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_PEEK;
					end
				end
				S_PEEK: begin
					if (sts.peek_free) begin
						res_q   <= ST_FREE;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					res_q   <= ST_ADJUSTED;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/nfgcs_dpath.sv]
`default_nettype none

module nfgcs_dpath #(
	parameter int GRID_WIDTH_MAX  = nfgcs_pkg::GRID_WIDTH_MAX_DEF,
	parameter int GRID_HEIGHT_MAX = nfgcs_pkg::GRID_HEIGHT_MAX_DEF,
	parameter int RADIUS_MAX      = nfgcs_pkg::RADIUS_MAX_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [nfgcs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nfgcs_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   opcode,
	input  logic signed [nfgcs_pkg::COORD_IN_W-1:0] cell_x,
	input  logic signed [nfgcs_pkg::COORD_IN_W-1:0] cell_y,
	input  logic                                   occupied,
	input  nfgcs_pkg::cmd_t                        cmd,
	output nfgcs_pkg::sts_t                        sts,
	output logic [nfgcs_pkg::STATUS_W-1:0]         status,
	output logic [nfgcs_pkg::OUT_XY_W-1:0]         found_x,
	output logic [nfgcs_pkg::OUT_XY_W-1:0]         found_y,
	output logic [nfgcs_pkg::SQ_W-1:0]             squared_distance
);
	import nfgcs_pkg::*;

	localparam int DEPTH = GRID_WIDTH_MAX * GRID_HEIGHT_MAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers
	logic [DIM_CFG_W-1:0] grid_width_q;
	logic [DIM_CFG_W-1:0] grid_height_q;
	logic [RAD_W-1:0]     radius_q;
	logic [SQ_W-1:0]      max_sq_q;

	// Captured request
	logic                         op_q;
	logic                         occ_q;
	logic signed [COORD_IN_W-1:0] x_q;
	logic signed [COORD_IN_W-1:0] y_q;

	// Occupancy store and clearing sweep
	logic          mem [DEPTH];
	logic          rd_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] req_addr;
	logic [AW-1:0] cand_addr;
	logic [AW-1:0] rd_addr;

	// Scan offsets and candidate
	logic signed [OFS_W-1:0]   dx_q;
	logic signed [OFS_W-1:0]   dy_q;
	logic signed [OFS_W-1:0]   r_pos;
	logic signed [OFS_W-1:0]   r_neg;
	logic [RAD_W-1:0]          r_eff;
	logic [DIM_W-1:0]          eff_w;
	logic [DIM_W-1:0]          eff_h;
	logic signed [COORD_W-1:0] req_cx;
	logic signed [COORD_W-1:0] req_cy;
	logic signed [COORD_W-1:0] cx;
	logic signed [COORD_W-1:0] cy;
	logic signed [2*OFS_W-1:0] dx2;
	logic signed [2*OFS_W-1:0] dy2;
	logic [SQ_W-1:0]           sq;
	logic                      cand_ok;

	// Candidate stage aligned with the store read
	logic                s1_valid;
	logic [OUT_XY_W-1:0] cx_s1;
	logic [OUT_XY_W-1:0] cy_s1;
	logic [SQ_W-1:0]     sq_s1;

	// Best so far
	logic                found_q;
	logic [OUT_XY_W-1:0] best_x_q;
	logic [OUT_XY_W-1:0] best_y_q;
	logic [SQ_W-1:0]     best_sq_q;

	// Result register
	logic [STATUS_W-1:0] status_q;
	logic [OUT_XY_W-1:0] fx_q;
	logic [OUT_XY_W-1:0] fy_q;
	logic [SQ_W-1:0]     dist_q;

	function automatic logic in_grid(input logic signed [COORD_W-1:0] c,
			input logic [DIM_W-1:0] lim);
		return !c[COORD_W-1] && (DIM_W'(c[COORD_W-2:0]) < lim);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic signed [COORD_W-1:0] xc,
			input logic signed [COORD_W-1:0] yc);
		return AW'(AW'(yc[COORD_W-2:0]) * AW'(GRID_WIDTH_MAX) + AW'(xc[COORD_W-2:0]));
	endfunction

	// Clip registers to the built sizes
	assign eff_w = (DIM_W'(grid_width_q) > DIM_W'(GRID_WIDTH_MAX)) ?
		DIM_W'(GRID_WIDTH_MAX) : DIM_W'(grid_width_q);
	assign eff_h = (DIM_W'(grid_height_q) > DIM_W'(GRID_HEIGHT_MAX)) ?
		DIM_W'(GRID_HEIGHT_MAX) : DIM_W'(grid_height_q);
	assign r_eff = (32'(radius_q) > RADIUS_MAX) ? RAD_W'(RADIUS_MAX) : radius_q;
	assign r_pos = $signed(OFS_W'(r_eff));
	assign r_neg = -r_pos;

	assign req_cx = COORD_W'(x_q);
	assign req_cy = COORD_W'(y_q);
	assign cx     = req_cx + COORD_W'(dx_q);
	assign cy     = req_cy + COORD_W'(dy_q);
	assign dx2    = dx_q * dx_q;
	assign dy2    = dy_q * dy_q;
	assign sq     = SQ_W'($unsigned(dx2 + dy2));
	assign cand_ok = (sq <= max_sq_q) && in_grid(cx, eff_w) && in_grid(cy, eff_h);

	assign req_addr  = addr_of(req_cx, req_cy);
	assign cand_addr = addr_of(cx, cy);
	assign rd_addr   = cmd.peek ? req_addr : cand_addr;

	assign sts.clr_done    = (clr_q == AW'(DEPTH - 1));
	assign sts.is_query    = (op_q == OP_QUERY);
	assign sts.req_in_grid = in_grid(req_cx, eff_w) && in_grid(req_cy, eff_h);
	assign sts.peek_free   = !rd_q;
	assign sts.scan_last   = (dx_q == r_pos) && (dy_q == r_pos);
	assign sts.found       = found_q;

	assign status           = status_q;
	assign found_x          = fx_q;
	assign found_y          = fy_q;
	assign squared_distance = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			radius_q      <= RADIUS_RST;
			max_sq_q      <= MAX_SQ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[DIM_CFG_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[DIM_CFG_W-1:0];
				REG_RADIUS:      radius_q      <= cfg_data[RAD_W-1:0];
				REG_MAX_SQ:      max_sq_q      <= cfg_data[SQ_W-1:0];
				default:         max_sq_q      <= max_sq_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			s1_valid <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			s1_valid <= cmd.scan_step && cand_ok;
			if (cmd.scan_init) begin
				found_q <= 1'b0;
			end else if (s1_valid && !rd_q && (!found_q || sq_s1 < best_sq_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			occ_q <= occupied;
			x_q   <= cell_x;
			y_q   <= cell_y;
		end
		if (cmd.clr_step) begin
			mem[clr_q] <= 1'b0;
		end else if (cmd.wr_cell) begin
			mem[req_addr] <= occ_q;
		end
		rd_q <= mem[rd_addr];

		// walk rows, columns inner
		if (cmd.scan_init) begin
			dx_q <= r_neg;
			dy_q <= r_neg;
		end else if (cmd.scan_step) begin
			if (dx_q == r_pos) begin
				dx_q <= r_neg;
				dy_q <= dy_q + OFS_W'(1);
			end else begin
				dx_q <= dx_q + OFS_W'(1);
			end
		end

		cx_s1 <= cx[OUT_XY_W-1:0];
		cy_s1 <= cy[OUT_XY_W-1:0];
		sq_s1 <= sq;

		// strict compare keeps the first of equal distances
		if (s1_valid && !rd_q && (!found_q || sq_s1 < best_sq_q)) begin
			best_x_q  <= cx_s1;
			best_y_q  <= cy_s1;
			best_sq_q <= sq_s1;
		end

		if (cmd.load_out) begin
			status_q <= cmd.res_status;
			case (cmd.res_status)
				ST_FREE: begin
					fx_q   <= x_q[OUT_XY_W-1:0];
					fy_q   <= y_q[OUT_XY_W-1:0];
					dist_q <= '0;
				end
				ST_ADJUSTED: begin
					fx_q   <= best_x_q;
					fy_q   <= best_y_q;
					dist_q <= best_sq_q;
				end
				default: begin
					fx_q   <= '0;
					fy_q   <= '0;
					dist_q <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/nfgcs_checker.sv]
`default_nettype none

`include "nearest_free_grid_cell_search_assert.svh"

module nfgcs_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [nfgcs_pkg::STATUS_W-1:0]         status,
	input logic [nfgcs_pkg::OUT_XY_W-1:0]         found_x,
	input logic [nfgcs_pkg::OUT_XY_W-1:0]         found_y,
	input logic [nfgcs_pkg::SQ_W-1:0]             squared_distance
);
	import nfgcs_pkg::*;

	// A stalled result beat holds
	`NFGCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_x) && $stable(found_y) && $stable(squared_distance))

	// One item in flight: busy right after an accepted beat
	`NFGCS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// Results without a cell carry zeros
	`NFGCS_ASSERT_NOW(a_zero_payload, out_valid && (status == ST_WRITTEN || status == ST_OOB || status == ST_NONE), found_x == '0 && found_y == '0 && squared_distance == '0)

	// The requested cell itself is at distance zero
	`NFGCS_ASSERT_NOW(a_free_dist, out_valid && status == ST_FREE, squared_distance == '0)

	// An adjusted cell is never the occupied request
	`NFGCS_ASSERT_NOW(a_adjusted_moved, out_valid && status == ST_ADJUSTED, squared_distance != '0)

endmodule

bind nearest_free_grid_cell_search nfgcs_checker u_nfgcs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.found_x          (found_x),
	.found_y          (found_y),
	.squared_distance (squared_distance)
);

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
	import nfgcs_pkg::*;

	// Store stride and size follow the default build of the block.
	localparam int CELLS            = GRID_WIDTH_MAX_DEF * GRID_HEIGHT_MAX_DEF;
	// Clearing sweep plus ~200 beats at a full radius-31 scan, long stalls on both sides,
	// then taken about four times over.
	localparam int CYCLE_LIMIT      = 4_000_000;
	// Long enough for the longest scan, over the full (2*31+1)^2 window, to show any misbehaviour.
	localparam int SETTLE_CYCLES    = 4000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int RANDOM_ROUNDS    = 6;
	localparam int BEATS_PER_ROUND  = 21;

	typedef struct packed {
		logic                         opcode;
		logic signed [COORD_IN_W-1:0] x;
		logic signed [COORD_IN_W-1:0] y;
		logic                         occ;
	} cell_beat_t;

	typedef struct packed {
		status_t               status;
		logic [OUT_XY_W-1:0]   fx;
		logic [OUT_XY_W-1:0]   fy;
		logic [SQ_W-1:0]       sq;
	} cell_answer_t;

	// Shadow of the occupancy grid and its settings; works out the answer to each
	// accepted beat and holds it until the block's result beat turns up.
	class free_cell_tracker;
		bit           occ_map [CELLS];
		int           cols_reg;
		int           rows_reg;
		int           reach_reg;
		int           reach_sq_reg;
		cell_answer_t awaited [$];
		int           mismatches;
		int           writes_seen;
		int           queries_seen;
		int           by_status [5];

		function new();
			cols_reg     = GRID_WIDTH_RST;
			rows_reg     = GRID_HEIGHT_RST;
			reach_reg    = RADIUS_RST;
			reach_sq_reg = MAX_SQ_RST;
		endfunction

		// Mirror a register write; the register keeps only its own width.
		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GRID_WIDTH:  cols_reg     = data[DIM_CFG_W-1:0];
				REG_GRID_HEIGHT: rows_reg     = data[DIM_CFG_W-1:0];
				REG_RADIUS:      reach_reg    = data[RAD_W-1:0];
				REG_MAX_SQ:      reach_sq_reg = data[SQ_W-1:0];
				default: ;
			endcase
		endfunction

		// Oversized dimensions clip to the store; zero leaves nothing on the grid.
		function bit on_grid(int x, int y);
			int w;
			int h;
			w = (cols_reg > GRID_WIDTH_MAX_DEF) ? GRID_WIDTH_MAX_DEF : cols_reg;
			h = (rows_reg > GRID_HEIGHT_MAX_DEF) ? GRID_HEIGHT_MAX_DEF : rows_reg;
			return x >= 0 && y >= 0 && x < w && y < h;
		endfunction

		function void note_beat(cell_beat_t b);
			cell_answer_t want;
			int           x;
			int           y;
			int           r;
			int           sq;
			int           best;
			bit           found;
			x    = $signed(b.x);
			y    = $signed(b.y);
			want = '0;
			want.status = ST_WRITTEN;
			if (b.opcode == OP_WRITE) begin
				writes_seen++;
				// Off-grid writes are dropped but still answered.
				if (on_grid(x, y))
					occ_map[y * GRID_WIDTH_MAX_DEF + x] = b.occ;
			end else begin
				queries_seen++;
				if (!on_grid(x, y)) begin
					want.status = ST_OOB;
				end else if (!occ_map[y * GRID_WIDTH_MAX_DEF + x]) begin
					want.status = ST_FREE;
					want.fx     = OUT_XY_W'(x);
					want.fy     = OUT_XY_W'(y);
				end else begin
					// Scan row by row; a strict compare keeps the first of equal distances.
					r     = (reach_reg > RADIUS_MAX_DEF) ? RADIUS_MAX_DEF : reach_reg;
					found = 1'b0;
					best  = 0;
					for (int dy = -r; dy <= r; dy++) begin
						for (int dx = -r; dx <= r; dx++) begin
							sq = dx * dx + dy * dy;
							if (sq <= reach_sq_reg && on_grid(x + dx, y + dy) &&
							    !occ_map[(y + dy) * GRID_WIDTH_MAX_DEF + x + dx] &&
							    (!found || sq < best)) begin
								found   = 1'b1;
								best    = sq;
								want.fx = OUT_XY_W'(x + dx);
								want.fy = OUT_XY_W'(y + dy);
							end
						end
					end
					if (found) begin
						want.status = ST_ADJUSTED;
						want.sq     = SQ_W'(best);
					end else begin
						want.status = ST_NONE;
						want.fx     = '0;
						want.fy     = '0;
					end
				end
			end
			awaited.insert(awaited.size(), want);
		endfunction

		function void check_answer(cell_answer_t got);
			cell_answer_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("tb: unexpected result beat: status %0d cell (%0d,%0d) sq %0d",
						got.status, got.fx, got.fy, got.sq);
				return;
			end
			want = awaited.pop_front();
			by_status[want.status]++;
			if (got.status !== want.status || got.fx !== want.fx ||
			    got.fy !== want.fy || got.sq !== want.sq) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("tb: mismatch: expected status %0d cell (%0d,%0d) sq %0d, got status %0d cell (%0d,%0d) sq %0d",
						want.status, want.fx, want.fy, want.sq,
						got.status, got.fx, got.fy, got.sq);
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_data;
	logic                         in_valid;
	logic                         in_ready;
	logic                         opcode;
	logic signed [COORD_IN_W-1:0] cell_x;
	logic signed [COORD_IN_W-1:0] cell_y;
	logic                         occupied;
	logic                         out_valid;
	logic                         out_ready;
	logic [STATUS_W-1:0]          status;
	logic [OUT_XY_W-1:0]          found_x;
	logic [OUT_XY_W-1:0]          found_y;
	logic [SQ_W-1:0]              squared_distance;

	free_cell_tracker book;
	cell_beat_t       batch [$];
	int               cycle_count = 0;
	int               grid_settings = 0;
	bit               steady_src = 1'b0;
	bit               steady_sink = 1'b0;

	nearest_free_grid_cell_search dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.cell_x           (cell_x),
		.cell_y           (cell_y),
		.occupied         (occupied),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.found_x          (found_x),
		.found_y          (found_y),
		.squared_distance (squared_distance)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: a hung handshake or a stuck scan ends here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: errors");
		$finish;
	end

	// Sample everything at the edge, before this edge's updates land.
	// Register writes go into the shadow first, results are retired before a new
	// beat is noted, so ordering within the edge never matters.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				book.set_reg(cfg_index, cfg_data);
			if (out_valid && out_ready)
				book.check_answer('{status_t'(status), found_x, found_y, squared_distance});
			if (in_valid && in_ready)
				book.note_beat('{opcode, cell_x, cell_y, occupied});
		end
	end

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	// Result side: accept freely, or hold off for a random stretch.
	initial begin
		int hold;
		hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (steady_sink || $urandom_range(0, 99) < 65) begin
				out_ready <= 1'b1;
			end else begin
				hold = pause_len() - 1;
				out_ready <= 1'b0;
			end
		end
	end

	task automatic queue_item(input logic op, input int x, input int y, input logic occ);
		cell_beat_t b;
		b = '{op, COORD_IN_W'(x), COORD_IN_W'(y), occ};
		batch.insert(batch.size(), b);
	endtask

	// Drive the queued beats. Valid stays up across back-to-back beats and drops
	// only before a gap or after the last one, so it is never lowered and raised
	// in one step.
	task automatic send_batch();
		int gap;
		for (int i = 0; i < batch.size(); i++) begin
			opcode   <= batch[i].opcode;
			cell_x   <= batch[i].x;
			cell_y   <= batch[i].y;
			occupied <= batch[i].occ;
			in_valid <= 1'b1;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			if (i == batch.size() - 1)
				gap = 0;
			else if (steady_src || $urandom_range(0, 99) < 55)
				gap = 0;
			else
				gap = pause_len();
			if (gap > 0 || i == batch.size() - 1)
				in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		batch.delete();
	endtask

	// Hold until every answer is back, then let the block settle. Step one edge
	// first so the last accepted beat is already noted.
	task automatic wait_idle();
		@(posedge clk);
		while (book.awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges. Spare upper data bits are
	// randomised; each register keeps only its own width.
	task automatic apply_grid(input int cols, input int rows, input int reach, input int reach_sq);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data  <= CFG_DATA_W'(cols) | (CFG_DATA_W'($urandom_range(0, 3)) << DIM_CFG_W);
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data  <= CFG_DATA_W'(rows) | (CFG_DATA_W'($urandom_range(0, 3)) << DIM_CFG_W);
		@(posedge clk);
		cfg_index <= REG_RADIUS;
		cfg_data  <= CFG_DATA_W'(reach) | (CFG_DATA_W'($urandom_range(0, 63)) << RAD_W);
		@(posedge clk);
		cfg_index <= REG_MAX_SQ;
		cfg_data  <= CFG_DATA_W'(reach_sq);
		@(posedge clk);
		cfg_we    <= 1'b0;
		grid_settings++;
	endtask

	// Small grids dominate so that queries land on occupied cells; the rest
	// covers the full store, oversized values, zero and sizes in between.
	function automatic int pick_dim();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return $urandom_range(1, 12);
		if (roll < 78)
			return 256;
		if (roll < 86)
			return $urandom_range(257, 511);
		if (roll < 92)
			return 0;
		return $urandom_range(13, 255);
	endfunction

	initial begin
		int         cols;
		int         rows;
		int         reach;
		int         reach_sq;
		int         effc;
		int         effr;
		int         roll;
		int         x;
		int         y;
		logic       op;
		cell_beat_t recent [$];

		book = new();
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		opcode    <= OP_WRITE;
		cell_x    <= '0;
		cell_y    <= '0;
		occupied  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: full grid, zero radius and zero reach. The clearing
		// sweep runs first; the first beat simply waits for in_ready.
		queue_item(OP_WRITE, 0, 0, 1'b1);
		queue_item(OP_WRITE, 255, 255, 1'b1);
		queue_item(OP_WRITE, -1, 5, 1'b1);        // negative column: dropped
		queue_item(OP_WRITE, 256, 0, 1'b1);       // one past the last column: dropped
		queue_item(OP_QUERY, 0, 0, 1'b0);         // occupied, nothing in reach
		queue_item(OP_QUERY, 1, 0, 1'b1);         // free as requested
		queue_item(OP_QUERY, -1024, 1023, 1'b0);  // off the grid
		queue_item(OP_QUERY, 255, 255, 1'b0);     // far corner, occupied
		send_batch();
		wait_idle();

		// Oversized width, widest scan, distance limit above anything in the square.
		apply_grid(511, 256, 31, 2047);
		queue_item(OP_QUERY, 255, 255, 1'b0);     // moves up a row: first of the ties
		queue_item(OP_WRITE, 10, 10, 1'b1);
		queue_item(OP_WRITE, 10, 9, 1'b1);
		queue_item(OP_QUERY, 10, 10, 1'b0);       // cell above taken: tie goes left
		queue_item(OP_QUERY, 0, 0, 1'b1);         // corner: only right and down remain
		queue_item(OP_WRITE, 0, 0, 1'b0);
		queue_item(OP_QUERY, 0, 0, 1'b0);
		queue_item(OP_QUERY, 1023, -1024, 1'b1);
		send_batch();
		wait_idle();

		// Two-cell grid filled up: nothing free in reach.
		apply_grid(2, 1, 1, 2);
		queue_item(OP_WRITE, 0, 0, 1'b1);
		queue_item(OP_WRITE, 1, 0, 1'b1);
		queue_item(OP_QUERY, 1, 0, 1'b0);
		queue_item(OP_QUERY, 1, 1, 1'b0);
		queue_item(OP_WRITE, 255, 255, 1'b0);     // outside the shrunk grid: kept occupied
		send_batch();
		wait_idle();

		// Zero width: every cell is off the grid.
		apply_grid(0, 256, 3, 18);
		queue_item(OP_QUERY, 0, 0, 1'b0);
		queue_item(OP_WRITE, 3, 3, 1'b1);
		send_batch();
		wait_idle();

		// Grow back: the corner is still occupied, the dropped write left no mark.
		apply_grid(256, 256, 2, 0);
		queue_item(OP_QUERY, 255, 255, 1'b0);
		queue_item(OP_QUERY, 3, 3, 1'b0);
		send_batch();
		wait_idle();

		for (int round = 0; round < RANDOM_ROUNDS; round++) begin
			cols = (round == 1) ? 1 : pick_dim();
			rows = pick_dim();
			// Keep most scans short; the first round takes the widest window.
			if (round == 0)
				reach = RADIUS_MAX_DEF;
			else if ($urandom_range(0, 99) < 85)
				reach = $urandom_range(0, 4);
			else
				reach = $urandom_range(5, RADIUS_MAX_DEF);
			roll = $urandom_range(0, 99);
			if (roll < 55)
				reach_sq = $urandom_range(0, 2 * reach * reach);
			else if (roll < 75)
				reach_sq = 2047;
			else
				reach_sq = $urandom_range(0, 2047);
			// Some rounds run without idling on one side.
			steady_src  = (round == 2);
			steady_sink = (round == 3);
			apply_grid(cols, rows, reach, reach_sq);

			effc = (cols > GRID_WIDTH_MAX_DEF) ? GRID_WIDTH_MAX_DEF : cols;
			effr = (rows > GRID_HEIGHT_MAX_DEF) ? GRID_HEIGHT_MAX_DEF : rows;
			recent.delete();
			for (int n = 0; n < BEATS_PER_ROUND; n++) begin
				roll = $urandom_range(0, 99);
				op   = (roll < 45) ? OP_WRITE : OP_QUERY;
				if (effc == 0 || effr == 0 || $urandom_range(0, 99) < 15) begin
					// Anywhere in the coordinate range, negatives included.
					x = $signed(COORD_IN_W'($urandom));
					y = $signed(COORD_IN_W'($urandom));
				end else if (op == OP_QUERY && recent.size() != 0 &&
				             $urandom_range(0, 1) == 1) begin
					// Aim queries at written cells so the scan gets exercised.
					roll = $urandom_range(0, recent.size() - 1);
					x    = $signed(recent[roll].x);
					y    = $signed(recent[roll].y);
				end else begin
					x = $urandom_range(0, effc - 1);
					y = $urandom_range(0, effr - 1);
				end
				queue_item(op, x, y, $urandom_range(0, 99) < 75);
				if (op == OP_WRITE)
					recent.insert(recent.size(), batch[batch.size() - 1]);
			end
			send_batch();
			wait_idle();
		end
		steady_src  = 1'b0;
		steady_sink = 1'b0;

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb: %0d writes and %0d queries under %0d grid settings after the reset one",
			book.writes_seen, book.queries_seen, grid_settings);
		$display("tb: answers free %0d, adjusted %0d, off grid %0d, none %0d; mismatches %0d",
			book.by_status[ST_FREE], book.by_status[ST_ADJUSTED], book.by_status[ST_OOB],
			book.by_status[ST_NONE], book.mismatches);
		if (book.mismatches == 0 && book.awaited.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
